### src/gg_pkg.sv
// gg_pkg: constants, payload structs and state encoding for the gap-filling grid store
// used by grid_gap_fill_nearest and tb; no dependencies

package gg_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int WORD_WIDTH = 64;
    localparam int CELLS      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(CELLS);

    // field widths fixed by the item format
    localparam int ROW_W = 5;
    localparam int COL_W = 5;
    localparam int DIM_W = 6;
    // search radius reaches rows + cols, offsets cover row +/- radius
    localparam int RAD_W = DIM_W + 1;
    localparam int OFS_W = RAD_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // register index is paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(32);
    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(32);

    typedef struct packed {
        logic                  opcode;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [WORD_WIDTH-1:0] cell_word;
        logic                  cell_valid;
    } t_in_item;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] filled_word;
        logic                  filled_valid;
        logic                  from_neighbour;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } t_state;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

### src/gg_ram.sv
// gg_ram: generic single-write, single-read memory with registered read data
// no dependencies

module gg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/grid_gap_fill_nearest.sv
// grid_gap_fill_nearest: grid store of words with valid marks and nearest-cell gap filling
// depends on gg_pkg and gg_ram
//
// Usage: one input channel (i_in_valid/o_in_ready, payload t_in_item) carries write and
// read beats; one output channel (o_out_valid/i_out_ready, payload t_out_item) returns one
// beat per read and nothing for a write. rows_in_use and cols_in_use sit on the APB port
// at byte addresses 0 and 4; pready is tied high.
// A write beat is stored into the grid memory at once when it is accepted.
// A read beat starts a search sequencer: each probe computes one candidate cell with a
// shared offset adder and bounds compare; a candidate inside the grid takes a memory read
// in ST_PROBE, then a mark check in ST_CHECK; one outside it is skipped in ST_PROBE. The own
// cell comes first, then Manhattan radius 1 up to rows + cols. Out-of-range reads skip the
// search and go straight to ST_DONE with an empty result. Input is not taken while a search
// runs; the next beat is taken once the result has moved into the output register.
// A finished result waits in an output register; the receiver may stall freely, and
// further writes are still taken; the next read's result waits until the register frees.
// After reset a clearing pass writes every cell mark to zero, one cell a cycle;
// o_in_ready stays low meanwhile. APB writes are taken at any time.

module grid_gap_fill_nearest (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gg_pkg::t_in_item   i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gg_pkg::t_out_item  o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    gg_pkg::t_state                r_state, n_state;
    logic [gg_pkg::DIM_W-1:0]      r_rows, r_cols;
    logic [gg_pkg::ROW_W-1:0]      r_row, n_row;
    logic [gg_pkg::COL_W-1:0]      r_col, n_col;
    logic [gg_pkg::RAD_W-1:0]      r_rad, n_rad;
    logic [gg_pkg::RAD_W-1:0]      r_d, n_d;
    logic [1:0]                    r_sign, n_sign;
    logic [gg_pkg::ADDR_W-1:0]     r_clr, n_clr;
    gg_pkg::t_out_item             r_res, n_res;
    gg_pkg::t_out_item             r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic [gg_pkg::DIM_W-1:0]      w_nr, w_nc;
    logic [gg_pkg::RAD_W-1:0]      w_limit;
    logic [gg_pkg::RAD_W-1:0]      w_e;
    logic signed [gg_pkg::OFS_W-1:0] w_row_s, w_col_s, w_d_s, w_e_s, w_cr, w_cc;
    logic signed [gg_pkg::OFS_W-1:0] w_nr_s, w_nc_s;
    logic                          w_in_grid;
    logic [gg_pkg::ADDR_W-1:0]     w_cand_addr;

    logic                          w_adv_done;
    logic [gg_pkg::RAD_W-1:0]      w_adv_rad, w_adv_d;
    logic [1:0]                    w_adv_sign;

    logic                          w_wr_en, w_rd_en;
    logic [gg_pkg::ADDR_W-1:0]     w_wr_addr, w_rd_addr;
    logic [gg_pkg::WORD_WIDTH:0]   w_wr_data, w_rd_data;
    logic                          w_in_beat, w_cfg_wr;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gg_pkg::ROWS_RESET;
            r_cols <= gg_pkg::COLS_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                gg_pkg::REG_ROWS: r_rows <= pwdata[gg_pkg::DIM_W-1:0];
                gg_pkg::REG_COLS: r_cols <= pwdata[gg_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            gg_pkg::REG_ROWS: prdata = {{(32-gg_pkg::DIM_W){1'b0}}, r_rows};
            gg_pkg::REG_COLS: prdata = {{(32-gg_pkg::DIM_W){1'b0}}, r_cols};
            default:          prdata = '0;
        endcase
    end

    // oversized sizes act as the storage size
    assign w_nr = (int'(r_rows) > gg_pkg::MAX_ROWS) ? gg_pkg::DIM_W'(gg_pkg::MAX_ROWS) : r_rows;
    assign w_nc = (int'(r_cols) > gg_pkg::MAX_COLS) ? gg_pkg::DIM_W'(gg_pkg::MAX_COLS) : r_cols;
    assign w_limit = {1'b0, w_nr} + {1'b0, w_nc};

    // ---------------- shared probe unit ----------------
    assign w_e     = r_rad - r_d;
    assign w_row_s = $signed({{(gg_pkg::OFS_W-gg_pkg::ROW_W){1'b0}}, r_row});
    assign w_col_s = $signed({{(gg_pkg::OFS_W-gg_pkg::COL_W){1'b0}}, r_col});
    assign w_d_s   = $signed({{(gg_pkg::OFS_W-gg_pkg::RAD_W){1'b0}}, r_d});
    assign w_e_s   = $signed({{(gg_pkg::OFS_W-gg_pkg::RAD_W){1'b0}}, w_e});
    assign w_nr_s  = $signed({{(gg_pkg::OFS_W-gg_pkg::DIM_W){1'b0}}, w_nr});
    assign w_nc_s  = $signed({{(gg_pkg::OFS_W-gg_pkg::DIM_W){1'b0}}, w_nc});

    // sign order ++, +-, -+, -- : high bit picks row sign, low bit column sign
    assign w_cr = r_sign[1] ? (w_row_s - w_d_s) : (w_row_s + w_d_s);
    assign w_cc = r_sign[0] ? (w_col_s - w_e_s) : (w_col_s + w_e_s);

    assign w_in_grid = (w_cr >= 0) && (w_cc >= 0) && (w_cr < w_nr_s) && (w_cc < w_nc_s);
    assign w_cand_addr = gg_pkg::cell_addr(w_cr[gg_pkg::ROW_W-1:0], w_cc[gg_pkg::COL_W-1:0]);

    // next candidate in search order
    always_comb begin
        w_adv_done = 1'b0;
        w_adv_rad  = r_rad;
        w_adv_d    = r_d;
        w_adv_sign = r_sign + 2'd1;
        if (r_rad == '0) begin
            w_adv_rad  = gg_pkg::RAD_W'(1);
            w_adv_d    = '0;
            w_adv_sign = '0;
        end else if (r_sign != 2'd3) begin
            w_adv_sign = r_sign + 2'd1;
        end else begin
            w_adv_sign = '0;
            if (r_d != r_rad) begin
                w_adv_d = r_d + gg_pkg::RAD_W'(1);
            end else if (r_rad >= w_limit) begin
                w_adv_done = 1'b1;
            end else begin
                w_adv_rad = r_rad + gg_pkg::RAD_W'(1);
                w_adv_d   = '0;
            end
        end
    end

    // ---------------- sequencer ----------------
    assign o_in_ready = (r_state == gg_pkg::ST_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gg_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_rad  <= n_rad;
        r_d    <= n_d;
        r_sign <= n_sign;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_rad       = r_rad;
        n_d         = r_d;
        n_sign      = r_sign;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_wr_en     = 1'b0;
        w_wr_addr   = gg_pkg::cell_addr(i_in_item.row, i_in_item.col);
        w_wr_data   = {i_in_item.cell_valid, i_in_item.cell_word};
        w_rd_en     = 1'b0;
        w_rd_addr   = w_cand_addr;

        case (r_state)
            gg_pkg::ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = '0;
                n_clr     = r_clr + gg_pkg::ADDR_W'(1);
                if (r_clr == gg_pkg::ADDR_W'(gg_pkg::CELLS - 1)) begin
                    n_state = gg_pkg::ST_IDLE;
                end
            end
            gg_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    if (i_in_item.opcode == gg_pkg::OP_WRITE) begin
                        w_wr_en = (int'(i_in_item.row) < gg_pkg::MAX_ROWS) &&
                                  (int'(i_in_item.col) < gg_pkg::MAX_COLS);
                    end else if (({1'b0, i_in_item.row} >= w_nr) ||
                                 ({1'b0, i_in_item.col} >= w_nc)) begin
                        n_res   = '0;
                        n_state = gg_pkg::ST_DONE;
                    end else begin
                        n_row   = i_in_item.row;
                        n_col   = i_in_item.col;
                        n_rad   = '0;
                        n_d     = '0;
                        n_sign  = '0;
                        n_state = gg_pkg::ST_PROBE;
                    end
                end
            end
            gg_pkg::ST_PROBE: begin
                if (w_in_grid) begin
                    w_rd_en = 1'b1;
                    n_state = gg_pkg::ST_CHECK;
                end else if (w_adv_done) begin
                    n_res   = '0;
                    n_state = gg_pkg::ST_DONE;
                end else begin
                    n_rad  = w_adv_rad;
                    n_d    = w_adv_d;
                    n_sign = w_adv_sign;
                end
            end
            gg_pkg::ST_CHECK: begin
                if (w_rd_data[gg_pkg::WORD_WIDTH]) begin
                    n_res.filled_word    = w_rd_data[gg_pkg::WORD_WIDTH-1:0];
                    n_res.filled_valid   = 1'b1;
                    n_res.from_neighbour = (r_rad != '0);
                    n_state              = gg_pkg::ST_DONE;
                end else if (w_adv_done) begin
                    n_res   = '0;
                    n_state = gg_pkg::ST_DONE;
                end else begin
                    n_rad   = w_adv_rad;
                    n_d     = w_adv_d;
                    n_sign  = w_adv_sign;
                    n_state = gg_pkg::ST_PROBE;
                end
            end
            gg_pkg::ST_DONE: begin
                // hand over once the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = gg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gg_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // word and valid mark share one entry, mark in the top bit
    gg_ram #(
        .WIDTH(gg_pkg::WORD_WIDTH + 1),
        .DEPTH(gg_pkg::CELLS)
    ) u_grid (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // ---------------- assertions ----------------
    a_check_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gg_pkg::ST_CHECK) |-> ($past(r_state) == gg_pkg::ST_PROBE))
        else $error("mark check without a preceding probe");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gg_pkg::ST_PROBE) |-> (r_d <= r_rad))
        else $error("row offset beyond search radius");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == gg_pkg::ST_DONE))
        else $error("result beat raised outside done state");

    a_neighbour_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.from_neighbour) |-> o_out_item.filled_valid)
        else $error("neighbour flag on a result without a valid word");

    a_no_accept_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == gg_pkg::ST_PROBE) || (r_state == gg_pkg::ST_CHECK)) |-> !w_wr_en)
        else $error("grid written while a search runs");

endmodule

### test/tb.sv
// tb: self-checking testbench for grid_gap_fill_nearest, directed table then random phases
// depends on gg_pkg and the block's sources; drives valid/ready beats and the apb port

module tb;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 32;
    localparam int RUN_LIMIT       = 4_000_000;
    localparam int N_PHASES        = 10;
    localparam int BEATS_PER_PHASE = 85;

    typedef enum bit {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        gg_pkg::t_in_item  item;
        bit                pinned;
        gg_pkg::t_out_item pinned_res;
    } t_stim_beat;

    typedef struct {
        t_row_kind         kind;
        gg_pkg::t_in_item  item;
        bit                pinned;
        gg_pkg::t_out_item pinned_res;
        logic              reg_idx;
        logic [5:0]        reg_val;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    gg_pkg::t_in_item  i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    gg_pkg::t_out_item o_out_item;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // own copy of the grid and the in-use sizes
    logic [gg_pkg::WORD_WIDTH-1:0] grid_words [gg_pkg::CELLS];
    bit                            grid_marks [gg_pkg::CELLS];
    logic [gg_pkg::DIM_W-1:0]      rows_cfg = gg_pkg::ROWS_RESET;
    logic [gg_pkg::DIM_W-1:0]      cols_cfg = gg_pkg::COLS_RESET;

    t_stim_beat        beat_q[$];
    t_stim_beat        cur_beat;
    gg_pkg::t_out_item fill_q[$];
    t_dir_row          dir_tab[$];

    int in_idle_pct  = 10;
    int out_idle_pct = 10;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    grid_gap_fill_nearest u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int eff_dim(input logic [gg_pkg::DIM_W-1:0] v, input int max_v);
        return (int'(v) > max_v) ? max_v : int'(v);
    endfunction

    // nearest valid stored cell by manhattan radius, signs ++ +- -+ --
    function automatic gg_pkg::t_out_item predict_fill(input logic [gg_pkg::ROW_W-1:0] row,
                                                       input logic [gg_pkg::COL_W-1:0] col);
        int nr, nc, r, c, rad, d, e, a, b, cr, cc, addr;
        gg_pkg::t_out_item res;
        res = '0;
        nr  = eff_dim(rows_cfg, gg_pkg::MAX_ROWS);
        nc  = eff_dim(cols_cfg, gg_pkg::MAX_COLS);
        r   = int'(row);
        c   = int'(col);
        if (r >= nr || c >= nc)
            return res;
        addr = r * gg_pkg::MAX_COLS + c;
        if (grid_marks[addr]) begin
            res.filled_word  = grid_words[addr];
            res.filled_valid = 1'b1;
            return res;
        end
        for (rad = 1; rad <= nr + nc; rad++) begin
            for (d = 0; d <= rad; d++) begin
                e = rad - d;
                for (a = 0; a < 2; a++) begin
                    for (b = 0; b < 2; b++) begin
                        cr = (a == 0) ? r + d : r - d;
                        cc = (b == 0) ? c + e : c - e;
                        if (cr >= 0 && cc >= 0 && cr < nr && cc < nc) begin
                            addr = cr * gg_pkg::MAX_COLS + cc;
                            if (grid_marks[addr]) begin
                                res.filled_word    = grid_words[addr];
                                res.filled_valid   = 1'b1;
                                res.from_neighbour = 1'b1;
                                return res;
                            end
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic t_dir_row beat_row(input logic op, input logic [gg_pkg::ROW_W-1:0] row,
                                          input logic [gg_pkg::COL_W-1:0] col,
                                          input logic [gg_pkg::WORD_WIDTH-1:0] word,
                                          input logic mark);
        t_dir_row t;
        t.kind            = ROW_BEAT;
        t.item            = '0;
        t.pinned          = 1'b0;
        t.pinned_res      = '0;
        t.reg_idx         = 1'b0;
        t.reg_val         = '0;
        t.item.opcode     = op;
        t.item.row        = row;
        t.item.col        = col;
        t.item.cell_word  = word;
        t.item.cell_valid = mark;
        return t;
    endfunction

    function automatic t_dir_row pin_row(input t_dir_row base,
                                         input logic [gg_pkg::WORD_WIDTH-1:0] w,
                                         input logic v, input logic nb);
        t_dir_row t;
        t                           = base;
        t.pinned                    = 1'b1;
        t.pinned_res.filled_word    = w;
        t.pinned_res.filled_valid   = v;
        t.pinned_res.from_neighbour = nb;
        return t;
    endfunction

    function automatic t_dir_row cfg_row(input logic idx, input logic [5:0] val);
        t_dir_row t;
        t.kind       = ROW_CFG;
        t.item       = '0;
        t.pinned     = 1'b0;
        t.pinned_res = '0;
        t.reg_idx    = idx;
        t.reg_val    = val;
        return t;
    endfunction

    // sender
    always @(posedge i_clk) begin : drive_in
        t_stim_beat nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (beat_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                nxt = beat_q.pop_front();
                cur_beat   <= nxt;
                i_in_item  <= nxt.item;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watch
        gg_pkg::t_out_item want;
        int                addr;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (cur_beat.item.opcode == gg_pkg::OP_READ) begin
                    fill_q.push_back(cur_beat.pinned ? cur_beat.pinned_res
                                     : predict_fill(cur_beat.item.row, cur_beat.item.col));
                end else begin
                    addr = int'(cur_beat.item.row) * gg_pkg::MAX_COLS
                         + int'(cur_beat.item.col);
                    grid_words[addr] = cur_beat.item.cell_word;
                    grid_marks[addr] = cur_beat.item.cell_valid;
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (fill_q.size() == 0) begin
                    $display("%0t: result beat with none expected, got %h", $time, o_out_item);
                    err_cnt++;
                end else begin
                    want = fill_q.pop_front();
                    if (want.filled_word !== o_out_item.filled_word) begin
                        $display("%0t: filled_word expected %h got %h", $time,
                                 want.filled_word, o_out_item.filled_word);
                        err_cnt++;
                    end
                    if (want.filled_valid !== o_out_item.filled_valid) begin
                        $display("%0t: filled_valid expected %b got %b", $time,
                                 want.filled_valid, o_out_item.filled_valid);
                        err_cnt++;
                    end
                    if (want.from_neighbour !== o_out_item.from_neighbour) begin
                        $display("%0t: from_neighbour expected %b got %b", $time,
                                 want.from_neighbour, o_out_item.from_neighbour);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sampled at the falling edge so the queues and valid are settled
    task automatic wait_idle();
        while (beat_q.size() != 0 || i_in_valid || fill_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write then read back of one size register
    task automatic set_dim(input logic idx, input logic [5:0] val);
        logic [31:0] wd;
        wd = $urandom;
        wd[gg_pkg::DIM_W-1:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == gg_pkg::REG_ROWS)
            rows_cfg = val;
        else
            cols_cfg = val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(val)) begin
            $display("%0t: register %0d read expected %h got %h", $time, idx, 32'(val), prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly cells inside the in-use grid, some anywhere in storage
    task automatic queue_random_beats(input int n);
        t_stim_beat b;
        int er, ec, roll;
        er = eff_dim(rows_cfg, gg_pkg::MAX_ROWS);
        ec = eff_dim(cols_cfg, gg_pkg::MAX_COLS);
        repeat (n) begin
            b.pinned      = 1'b0;
            b.pinned_res  = '0;
            b.item.opcode = ($urandom_range(99) < 45) ? gg_pkg::OP_WRITE : gg_pkg::OP_READ;
            if (er > 0 && ec > 0 && $urandom_range(99) < 85) begin
                b.item.row = gg_pkg::ROW_W'($urandom_range(er - 1));
                b.item.col = gg_pkg::COL_W'($urandom_range(ec - 1));
            end else begin
                b.item.row = gg_pkg::ROW_W'($urandom_range(gg_pkg::MAX_ROWS - 1));
                b.item.col = gg_pkg::COL_W'($urandom_range(gg_pkg::MAX_COLS - 1));
            end
            roll = $urandom_range(99);
            if (roll < 4)
                b.item.cell_word = '0;
            else if (roll < 8)
                b.item.cell_word = '1;
            else
                b.item.cell_word = {$urandom, $urandom};
            b.item.cell_valid = ($urandom_range(99) < 80);
            beat_q.push_back(b);
        end
    endtask

    initial begin : main
        t_stim_beat               sb;
        logic [gg_pkg::DIM_W-1:0] nr, nc;
        int                       ph;

        foreach (grid_marks[i]) begin
            grid_marks[i] = 1'b0;
            grid_words[i] = '0;
        end

        // empty grid after reset, then extremes of words and cells
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 0, 0, '0, 1'b0), '0, 1'b0, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 5, 5, '1, 1'b1));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 5, 5, '0, 1'b0), '1, 1'b1, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 0, 0, '0, 1'b1));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 0, 0, '1, 1'b1), '0, 1'b1, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_READ, 5, 6, '0, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 31, 31, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 31, 31, '0, 1'b0),
                                  64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 1'b0));
        // gap over a valid word, filled values are never written back
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 5, 5, 64'h0123_4567_89AB_CDEF, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_READ, 5, 5, '0, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_READ, 5, 5, '0, 1'b0));
        // zero rows in use
        dir_tab.push_back(cfg_row(gg_pkg::REG_ROWS, 6'd0));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 0, 0, '0, 1'b0), '0, 1'b0, 1'b0));
        // oversized registers act as the full grid
        dir_tab.push_back(cfg_row(gg_pkg::REG_ROWS, 6'd63));
        dir_tab.push_back(cfg_row(gg_pkg::REG_COLS, 6'd33));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 31, 31, '0, 1'b0),
                                  64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 1'b0));
        // small grid: outside reads, writes outside still stored
        dir_tab.push_back(cfg_row(gg_pkg::REG_ROWS, 6'd4));
        dir_tab.push_back(cfg_row(gg_pkg::REG_COLS, 6'd4));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 5, 5, '0, 1'b0), '0, 1'b0, 1'b0));
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 31, 0, 64'hFEED_0000_0000_BEEF, 1'b1));
        dir_tab.push_back(beat_row(gg_pkg::OP_READ, 2, 3, '0, 1'b0));
        dir_tab.push_back(cfg_row(gg_pkg::REG_ROWS, 6'd32));
        dir_tab.push_back(cfg_row(gg_pkg::REG_COLS, 6'd32));
        dir_tab.push_back(beat_row(gg_pkg::OP_READ, 31, 1, '0, 1'b0));
        // single cell grid holding a gap: nothing found
        dir_tab.push_back(cfg_row(gg_pkg::REG_ROWS, 6'd1));
        dir_tab.push_back(cfg_row(gg_pkg::REG_COLS, 6'd1));
        dir_tab.push_back(beat_row(gg_pkg::OP_WRITE, 0, 0, '1, 1'b0));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 0, 0, '0, 1'b0), '0, 1'b0, 1'b0));
        dir_tab.push_back(pin_row(beat_row(gg_pkg::OP_READ, 0, 1, '0, 1'b0), '0, 1'b0, 1'b0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                set_dim(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                sb.item       = dir_tab[i].item;
                sb.pinned     = dir_tab[i].pinned;
                sb.pinned_res = dir_tab[i].pinned_res;
                beat_q.push_back(sb);
            end
        end
        wait_idle();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    nr = 6'd32;
                    nc = 6'd32;
                end
                1: begin
                    nr = 6'd1;
                    nc = 6'd32;
                end
                2: begin
                    nr = 6'd32;
                    nc = 6'd1;
                end
                3: begin
                    nr = gg_pkg::DIM_W'($urandom_range(33, 63));
                    nc = gg_pkg::DIM_W'($urandom_range(33, 63));
                end
                4: begin
                    nr = 6'd0;
                    nc = gg_pkg::DIM_W'($urandom_range(1, 8));
                end
                7: begin
                    nr = gg_pkg::DIM_W'($urandom_range(1, 8));
                    nc = 6'd0;
                end
                default: begin
                    nr = gg_pkg::DIM_W'($urandom_range(1, 8));
                    nc = gg_pkg::DIM_W'($urandom_range(1, 8));
                end
            endcase
            // one phase runs flat out on both sides
            in_idle_pct  = (ph == 5) ? 0 : 10;
            out_idle_pct = (ph == 5) ? 0 : 10;
            set_dim(gg_pkg::REG_ROWS, nr);
            set_dim(gg_pkg::REG_COLS, nc);
            queue_random_beats(BEATS_PER_PHASE);
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
